// ===== src/dlir_pkg.sv =====
package dlir_pkg;

  // store geometry, fixed by the 8-bit element index
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 8;
  localparam int unsigned STORE_DEPTH = 256;

  // operation codes carried in tuser
  localparam logic [1:0] OP_LOAD_LEFT   = 2'd0;
  localparam logic [1:0] OP_LOAD_WEIGHT = 2'd1;
  localparam logic [1:0] OP_LOAD_BIAS   = 2'd2;
  localparam logic [1:0] OP_COMPUTE     = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_INNER = 2'd0;
  localparam logic [1:0] CFG_COLS  = 2'd1;
  localparam logic [1:0] CFG_BIAS  = 2'd2;

  // per-cycle command broadcast to every cell of the row
  typedef struct packed {
    logic shift_w;    // shift operand chain up by one cell
    logic clear;      // zero the accumulators
    logic prod_en;    // latch a * w into the product register
    logic acc_prod;   // acc += product
    logic acc_w;      // acc += operand (bias pass)
    logic shift_out;  // shift accumulators down toward cell 0
  } cell_ctrl_t;

endpackage

// ===== src/dense_layer_int_relu_unit.sv =====
// Channel   Direction  Handshake              Payload
// in_       slave      in_tvalid / in_tready  tuser: operation; tdata: index, row, value
// out_      master     out_tvalid / out_tready tdata: result_value, column; tlast: last
// cfg_      write      cfg_we                 cfg_index, cfg_wdata
//
// Load items are accepted back to back while no compute item is running.
// A compute item runs the dot products, then a bias pass when enabled, then the
// drain (inner length and columns both clamped); the single read port of each
// store feeds one operand per cycle into the cell row.
// Reset (rst_n, synchronous) clears control only; store contents start undefined.
// Output stalls hold the drain; in_tready is low until the last result leaves the row.
module dense_layer_int_relu_unit #(
  parameter int unsigned MAX_ROWS  = 16,
  parameter int unsigned MAX_INNER = 16,
  parameter int unsigned MAX_COLS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] operation
  input  logic [47:0] in_tdata,   // [7:0] element_index, [11:8] row_index, [43:12] element_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [30:0] result_value, [34:31] column
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_wdata
);

  localparam int unsigned AW = dlir_pkg::ADDR_W;
  localparam int unsigned DW = dlir_pkg::DATA_W;

  logic          in_acc;
  logic [1:0]    in_op;
  logic [AW-1:0] in_index;
  logic [3:0]    in_row;
  logic [DW-1:0] in_value;

  logic [4:0]    inner_cnt_r;
  logic [4:0]    col_cnt_r;
  logic          bias_en_r;

  logic                 busy;
  logic [AW-1:0]        left_raddr, weight_raddr, bias_raddr;
  logic [DW-1:0]        left_rdata, weight_rdata, bias_rdata;
  logic                 bias_sel;
  dlir_pkg::cell_ctrl_t ctl;
  logic [3:0]           drain_col;
  logic                 drain_last;
  logic                 out_free;

  logic [DW-1:0] a_r;
  logic [DW-1:0] chain_in;
  logic [DW-1:0] w_bus   [MAX_COLS];
  logic [DW-1:0] acc_bus [MAX_COLS];
  logic [DW-1:0] acc_up  [MAX_COLS];
  logic [DW-1:0] w_down  [MAX_COLS];

  logic          out_tvalid_r;
  logic [30:0]   out_value_r;
  logic [3:0]    out_col_r;
  logic          out_last_r;

  // input unpacking
  assign in_acc   = in_tvalid & in_tready;
  assign in_op    = in_tuser;
  assign in_index = in_tdata[7:0];
  assign in_row   = in_tdata[11:8];
  assign in_value = in_tdata[43:12];
  assign in_tready = !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_cnt_r <= 5'd1;
      col_cnt_r   <= 5'd1;
      bias_en_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        dlir_pkg::CFG_INNER: inner_cnt_r <= cfg_wdata;
        dlir_pkg::CFG_COLS:  col_cnt_r   <= cfg_wdata;
        dlir_pkg::CFG_BIAS:  bias_en_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // element stores
  dlir_ram #(.WIDTH(DW), .DEPTH(dlir_pkg::STORE_DEPTH)) u_left_ram (
    .clk   (clk),
    .we    (in_acc && in_op == dlir_pkg::OP_LOAD_LEFT),
    .waddr (in_index),
    .wdata (in_value),
    .raddr (left_raddr),
    .rdata (left_rdata)
  );

  dlir_ram #(.WIDTH(DW), .DEPTH(dlir_pkg::STORE_DEPTH)) u_weight_ram (
    .clk   (clk),
    .we    (in_acc && in_op == dlir_pkg::OP_LOAD_WEIGHT),
    .waddr (in_index),
    .wdata (in_value),
    .raddr (weight_raddr),
    .rdata (weight_rdata)
  );

  dlir_ram #(.WIDTH(DW), .DEPTH(dlir_pkg::STORE_DEPTH)) u_bias_ram (
    .clk   (clk),
    .we    (in_acc && in_op == dlir_pkg::OP_LOAD_BIAS),
    .waddr (in_index),
    .wdata (in_value),
    .raddr (bias_raddr),
    .rdata (bias_rdata)
  );

  // sequencer
  dlir_ctrl #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_INNER (MAX_INNER),
    .MAX_COLS  (MAX_COLS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (in_acc && in_op == dlir_pkg::OP_COMPUTE),
    .row          (in_row),
    .inner_count  (inner_cnt_r),
    .col_count    (col_cnt_r),
    .bias_en      (bias_en_r),
    .out_free     (out_free),
    .busy         (busy),
    .left_raddr   (left_raddr),
    .weight_raddr (weight_raddr),
    .bias_raddr   (bias_raddr),
    .bias_sel     (bias_sel),
    .ctl          (ctl),
    .column       (drain_col),
    .last         (drain_last)
  );

  // left element, broadcast to every cell
  always_ff @(posedge clk) begin
    if (ctl.shift_w) begin
      a_r <= left_rdata;
    end
  end

  assign chain_in = bias_sel ? bias_rdata : weight_rdata;

  // row of MAC cells: operands move up, results drain down to cell 0
  for (genvar i = 0; i < MAX_COLS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign w_down[i] = chain_in;
    end else begin : g_body
      assign w_down[i] = w_bus[i-1];
    end
    if (i == MAX_COLS - 1) begin : g_tail
      assign acc_up[i] = '0;
    end else begin : g_mid
      assign acc_up[i] = acc_bus[i+1];
    end

    dlir_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .a       (a_r),
      .w_in    (w_down[i]),
      .w_out   (w_bus[i]),
      .acc_in  (acc_up[i]),
      .acc_out (acc_bus[i])
    );
  end

  // output register with ReLU
  assign out_free = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (ctl.shift_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift_out) begin
      out_value_r <= acc_bus[0][31] ? '0 : acc_bus[0][30:0];
      out_col_r   <= drain_col;
      out_last_r  <= drain_last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {5'b0, out_col_r, out_value_r};
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  // a drained result shows up in the output register next cycle
  a_drain_lands: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.shift_out |=> out_tvalid)
    else $error("drained result did not reach output register");

  // operand streaming and result draining never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.shift_w && ctl.shift_out))
    else $error("operand shift during drain");

  // a compute item with work to do closes the input
  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_op == dlir_pkg::OP_COMPUTE && col_cnt_r != 5'd0
     && 32'(in_row) < 32'(MAX_ROWS)) |=> !in_tready)
    else $error("input still ready after compute item");
`endif

endmodule

// ===== src/dlir_ram.sv =====
module dlir_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/dlir_cell.sv =====
module dlir_cell (
  input  logic                    clk,
  input  dlir_pkg::cell_ctrl_t    ctl,
  input  logic [31:0]             a,
  input  logic [31:0]             w_in,
  output logic [31:0]             w_out,
  input  logic [31:0]             acc_in,
  output logic [31:0]             acc_out
);

  logic [31:0] w_r, w_nxt;
  logic [31:0] prod_r, prod_nxt;
  logic [31:0] acc_r, acc_nxt;

  // operand passes up the row, product stays local, accumulator shifts down on drain
  always_comb begin
    w_nxt    = ctl.shift_w ? w_in : w_r;
    prod_nxt = ctl.prod_en ? a * w_r : prod_r;
    acc_nxt  = acc_r;
    if (ctl.clear) begin
      acc_nxt = '0;
    end else if (ctl.acc_prod) begin
      acc_nxt = acc_r + prod_r;
    end else if (ctl.acc_w) begin
      acc_nxt = acc_r + w_r;
    end else if (ctl.shift_out) begin
      acc_nxt = acc_in;
    end
  end

  always_ff @(posedge clk) begin
    w_r    <= w_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign w_out   = w_r;
  assign acc_out = acc_r;

endmodule

// ===== src/dlir_ctrl.sv =====
module dlir_ctrl #(
  parameter int unsigned MAX_ROWS  = 16,
  parameter int unsigned MAX_INNER = 16,
  parameter int unsigned MAX_COLS  = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [3:0]                 row,
  input  logic [4:0]                 inner_count,
  input  logic [4:0]                 col_count,
  input  logic                       bias_en,
  input  logic                       out_free,
  output logic                       busy,
  output logic [dlir_pkg::ADDR_W-1:0] left_raddr,
  output logic [dlir_pkg::ADDR_W-1:0] weight_raddr,
  output logic [dlir_pkg::ADDR_W-1:0] bias_raddr,
  output logic                       bias_sel,
  output dlir_pkg::cell_ctrl_t       ctl,
  output logic [3:0]                 column,
  output logic                       last
);

  localparam int unsigned KW = $clog2(MAX_INNER + 1);
  localparam int unsigned CW = $clog2(MAX_COLS + 1);
  localparam int unsigned AW = dlir_pkg::ADDR_W;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_ISSUE  = 4'd1;
  localparam logic [3:0] ST_WAIT   = 4'd2;
  localparam logic [3:0] ST_PROD   = 4'd3;
  localparam logic [3:0] ST_ACC    = 4'd4;
  localparam logic [3:0] ST_BISSUE = 4'd5;
  localparam logic [3:0] ST_BWAIT  = 4'd6;
  localparam logic [3:0] ST_BADD   = 4'd7;
  localparam logic [3:0] ST_DRAIN  = 4'd8;

  logic [3:0]    state_r, state_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [CW-1:0] jj_r, jj_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [3:0]    col_r, col_nxt;
  logic [AW-1:0] lbase_r, lbase_nxt;
  logic [AW-1:0] wbase_r, wbase_nxt;
  logic [AW-1:0] bbase_r, bbase_nxt;
  logic          shift_d_r, shift_d_nxt;
  logic          bias_d_r, bias_d_nxt;

  logic [KW-1:0] inner_eff;
  logic [CW-1:0] cols_eff;
  logic          row_ok;
  logic [11:0]   lprod;
  logic [11:0]   bprod;
  logic          issue;
  logic          bias_issue;

  // clamp the configured sizes to the row geometry
  assign inner_eff = (32'(inner_count) > 32'(MAX_INNER)) ? KW'(MAX_INNER) : KW'(inner_count);
  assign cols_eff  = (32'(col_count) > 32'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(col_count);
  assign row_ok    = 32'(row) < 32'(MAX_ROWS);

  // row base addresses, wrapped to the store depth
  assign lprod = 12'(row) * 12'(inner_eff);
  assign bprod = 12'(row) * 12'(cols_eff);

  // sequencer: per inner step, stream one weight row into the cells, then MAC; then optional bias pass and drain
  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    jj_nxt     = jj_r;
    cnt_nxt    = cnt_r;
    col_nxt    = col_r;
    lbase_nxt  = lbase_r;
    wbase_nxt  = wbase_r;
    bbase_nxt  = bbase_r;
    issue      = 1'b0;
    bias_issue = 1'b0;
    ctl        = '0;
    case (state_r)
      ST_IDLE: begin
        if (start && row_ok && cols_eff != '0) begin
          ctl.clear = 1'b1;
          jj_nxt    = cols_eff - CW'(1);
          k_nxt     = '0;
          wbase_nxt = '0;
          lbase_nxt = lprod[AW-1:0];
          bbase_nxt = bprod[AW-1:0];
          cnt_nxt   = cols_eff;
          col_nxt   = '0;
          if (inner_eff != '0) begin
            state_nxt = ST_ISSUE;
          end else if (bias_en) begin
            state_nxt = ST_BISSUE;
          end else begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_ISSUE: begin
        issue = 1'b1;
        if (jj_r == '0) begin
          state_nxt = ST_WAIT;
        end else begin
          jj_nxt = jj_r - CW'(1);
        end
      end
      ST_WAIT: begin
        state_nxt = ST_PROD;
      end
      ST_PROD: begin
        ctl.prod_en = 1'b1;
        state_nxt   = ST_ACC;
      end
      ST_ACC: begin
        ctl.acc_prod = 1'b1;
        k_nxt        = k_r + KW'(1);
        wbase_nxt    = wbase_r + AW'(cols_eff);
        jj_nxt       = cols_eff - CW'(1);
        if (k_r == inner_eff - KW'(1)) begin
          state_nxt = bias_en ? ST_BISSUE : ST_DRAIN;
        end else begin
          state_nxt = ST_ISSUE;
        end
      end
      ST_BISSUE: begin
        bias_issue = 1'b1;
        if (jj_r == '0) begin
          state_nxt = ST_BWAIT;
        end else begin
          jj_nxt = jj_r - CW'(1);
        end
      end
      ST_BWAIT: begin
        state_nxt = ST_BADD;
      end
      ST_BADD: begin
        ctl.acc_w = 1'b1;
        state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (out_free) begin
          ctl.shift_out = 1'b1;
          cnt_nxt       = cnt_r - CW'(1);
          col_nxt       = col_r + 4'd1;
          if (cnt_r == CW'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    // read data lands in the cycle after the address
    shift_d_nxt = issue | bias_issue;
    bias_d_nxt  = bias_issue;
    ctl.shift_w = shift_d_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      shift_d_r <= 1'b0;
      bias_d_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      shift_d_r <= shift_d_nxt;
      bias_d_r  <= bias_d_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r     <= k_nxt;
    jj_r    <= jj_nxt;
    col_r   <= col_nxt;
    lbase_r <= lbase_nxt;
    wbase_r <= wbase_nxt;
    bbase_r <= bbase_nxt;
  end

  assign busy         = state_r != ST_IDLE;
  assign left_raddr   = lbase_r + AW'(k_r);
  assign weight_raddr = wbase_r + AW'(jj_r);
  assign bias_raddr   = bbase_r + AW'(jj_r);
  assign bias_sel     = bias_d_r;
  assign column       = col_r;
  assign last         = cnt_r == CW'(1);

endmodule
